// ----- hdl/qvr_pkg.sv -----
// shared axis count and accumulator width helper for the quaternion vector rotator
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int AXES = 3;

  // accumulator width: three matrix-vector products plus the shifted vector term
  function automatic int acc_width(input int data_width, input int frac_bits);
    int prod_sum;
    int vec_term;
    prod_sum = 3 * data_width + 3;
    vec_term = data_width + 2 * frac_bits;
    return ((prod_sum > vec_term) ? prod_sum : vec_term) + 1;
  endfunction

endpackage

// ----- hdl/qvr_if.sv -----
// stream interfaces for the operand and result channels
`timescale 1ns / 1ps

interface qvr_operand_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                 input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
               output ready);
endinterface

interface qvr_result_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rot_x;
  logic signed [DATA_WIDTH-1:0] rot_y;
  logic signed [DATA_WIDTH-1:0] rot_z;
  logic                         saturated;

  modport source(output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink(input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

// ----- hdl/qvr_matrix.sv -----
// two pipeline stages: quaternion component products, then rotation matrix entries
`timescale 1ns / 1ps

module qvr_matrix import qvr_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [DATA_WIDTH-1:0]   qw,
  input  logic signed [DATA_WIDTH-1:0]   qx,
  input  logic signed [DATA_WIDTH-1:0]   qy,
  input  logic signed [DATA_WIDTH-1:0]   qz,
  input  logic signed [DATA_WIDTH-1:0]   vec_in [AXES],
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [2*DATA_WIDTH:0]   mat [AXES*AXES],
  output logic signed [DATA_WIDTH-1:0]   vec_out [AXES]
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int MW = PW + 1;

  logic                   a_valid;
  logic                   a_ready;
  logic                   b_ready;
  logic signed [PW-1:0]   pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [DATA_WIDTH-1:0] a_vec [AXES];

  assign a_ready   = !a_valid || b_ready;
  assign b_ready   = !out_valid || out_ready;
  assign in_ready  = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      pxx   <= PW'(qx) * PW'(qx);
      pyy   <= PW'(qy) * PW'(qy);
      pzz   <= PW'(qz) * PW'(qz);
      pxy   <= PW'(qx) * PW'(qy);
      pxz   <= PW'(qx) * PW'(qz);
      pyz   <= PW'(qy) * PW'(qz);
      pwx   <= PW'(qw) * PW'(qx);
      pwy   <= PW'(qw) * PW'(qy);
      pwz   <= PW'(qw) * PW'(qz);
      a_vec <= vec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      mat[0]  <= -(MW'(pyy) + MW'(pzz));
      mat[1]  <= MW'(pxy) - MW'(pwz);
      mat[2]  <= MW'(pxz) + MW'(pwy);
      mat[3]  <= MW'(pxy) + MW'(pwz);
      mat[4]  <= -(MW'(pxx) + MW'(pzz));
      mat[5]  <= MW'(pyz) - MW'(pwx);
      mat[6]  <= MW'(pxz) - MW'(pwy);
      mat[7]  <= MW'(pyz) + MW'(pwx);
      mat[8]  <= -(MW'(pxx) + MW'(pyy));
      vec_out <= a_vec;
    end
  end

endmodule

// ----- hdl/qvr_mat_apply.sv -----
// two pipeline stages: matrix-vector products, then row sums with vector term and rounding bias
`timescale 1ns / 1ps

module qvr_mat_apply import qvr_pkg::*; #(
  parameter  int DATA_WIDTH     = 16,
  parameter  int QUAT_FRAC_BITS = 14,
  localparam int ACC_WIDTH      = acc_width(DATA_WIDTH, QUAT_FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [2*DATA_WIDTH:0] mat [AXES*AXES],
  input  logic signed [DATA_WIDTH-1:0] vec_in [AXES],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ACC_WIDTH-1:0]  acc [AXES]
);

  localparam int PW = 3 * DATA_WIDTH + 1;
  localparam int SH = 2 * QUAT_FRAC_BITS - 1;
  localparam logic signed [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (SH - 1);

  logic                         c_valid;
  logic                         c_ready;
  logic                         d_ready;
  logic signed [PW-1:0]         prod [AXES*AXES];
  logic signed [DATA_WIDTH-1:0] c_vec [AXES];

  assign c_ready  = !c_valid || d_ready;
  assign d_ready  = !out_valid || out_ready;
  assign in_ready = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          prod[r*AXES+c] <= PW'(mat[r*AXES+c]) * PW'(vec_in[c]);
        end
      end
      c_vec <= vec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      for (int r = 0; r < AXES; r++) begin
        acc[r] <= ACC_WIDTH'(prod[r*AXES]) + ACC_WIDTH'(prod[r*AXES+1])
                  + ACC_WIDTH'(prod[r*AXES+2]) + (ACC_WIDTH'(c_vec[r]) <<< SH) + HALF;
      end
    end
  end

endmodule

// ----- hdl/qvr_round_sat.sv -----
// output stage: drop fraction bits, saturate to the data width, flag clipping
`timescale 1ns / 1ps

module qvr_round_sat import qvr_pkg::*; #(
  parameter  int DATA_WIDTH     = 16,
  parameter  int QUAT_FRAC_BITS = 14,
  localparam int ACC_WIDTH      = acc_width(DATA_WIDTH, QUAT_FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ACC_WIDTH-1:0]  acc [AXES],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] rot [AXES],
  output logic                         saturated
);

  localparam int SH = 2 * QUAT_FRAC_BITS - 1;
  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [DATA_WIDTH-1:0] clipped [AXES];
  logic [AXES-1:0]       ovf;

  assign in_ready = !out_valid || out_ready;

  // upper bits down to and including the sign bit of the result must all agree
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      ovf[i] = !(&acc[i][ACC_WIDTH-1:SH+DATA_WIDTH-1]) && (|acc[i][ACC_WIDTH-1:SH+DATA_WIDTH-1]);
      if (ovf[i]) begin
        clipped[i] = acc[i][ACC_WIDTH-1] ? MIN_VAL : MAX_VAL;
      end else begin
        clipped[i] = acc[i][SH+DATA_WIDTH-1:SH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int i = 0; i < AXES; i++) begin
        rot[i] <= $signed(clipped[i]);
      end
      saturated <= |ovf;
    end
  end

endmodule

// ----- hdl/quaternion_vector_rotate.sv -----
// each word is registered in turn as component products, matrix entries, row products, row sums, result
// throughput: one word per cycle while the output is not stalled; each of the five stages holds
// one word and moves on when the stage after it is free, so bubbles close up under back-pressure
// the widest stage is the matrix-vector multiply, (2*DATA_WIDTH+1) by DATA_WIDTH bits
// reset clears only the stage valid bits; no state is kept between words
`timescale 1ns / 1ps

module quaternion_vector_rotate import qvr_pkg::*; #(
  parameter int DATA_WIDTH     = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input logic          clk,
  input logic          rst,
  qvr_operand_if.sink  operand,
  qvr_result_if.source result
);

  localparam int ACC_WIDTH = acc_width(DATA_WIDTH, QUAT_FRAC_BITS);

  logic signed [DATA_WIDTH-1:0] vec_in [AXES];
  logic signed [2*DATA_WIDTH:0] mat [AXES*AXES];
  logic signed [DATA_WIDTH-1:0] mat_vec [AXES];
  logic signed [ACC_WIDTH-1:0]  acc [AXES];
  logic signed [DATA_WIDTH-1:0] rot [AXES];
  logic                         mat_valid, mat_ready;
  logic                         acc_valid, acc_ready;

  assign vec_in[0] = operand.vec_x;
  assign vec_in[1] = operand.vec_y;
  assign vec_in[2] = operand.vec_z;

  qvr_matrix #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .qw        (operand.quat_w),
    .qx        (operand.quat_x),
    .qy        (operand.quat_y),
    .qz        (operand.quat_z),
    .vec_in    (vec_in),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .mat       (mat),
    .vec_out   (mat_vec)
  );

  qvr_mat_apply #(
    .DATA_WIDTH    (DATA_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_mat_apply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .mat       (mat),
    .vec_in    (mat_vec),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .acc       (acc)
  );

  qvr_round_sat #(
    .DATA_WIDTH    (DATA_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_round_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .acc       (acc),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .rot       (rot),
    .saturated (result.saturated)
  );

  assign result.rot_x = rot[0];
  assign result.rot_y = rot[1];
  assign result.rot_z = rot[2];

endmodule

// ----- tb/sv/quaternion_vector_rotate_tb.sv -----
// self-checking testbench for the quaternion vector rotator: directed and random words
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;

  localparam int DW = 16;
  localparam int FRAC = 14;
  localparam int SHIFT = 2 * FRAC - 1;
  localparam longint ROT_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint ROT_MIN = -(longint'(1) <<< (DW - 1));
  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic signed [DW-1:0] quat_w;
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic signed [DW-1:0] vec_x;
    logic signed [DW-1:0] vec_y;
    logic signed [DW-1:0] vec_z;
    bit                   drain_first;
  } operand_word_t;

  typedef struct {
    logic signed [DW-1:0] rot_x;
    logic signed [DW-1:0] rot_y;
    logic signed [DW-1:0] rot_z;
    logic                 saturated;
  } rotation_t;

  typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic clk = 1'b0;
  logic rst;

  qvr_operand_if #(.DATA_WIDTH(DW)) operand ();
  qvr_result_if #(.DATA_WIDTH(DW)) result ();

  quaternion_vector_rotate #(
    .DATA_WIDTH(DW),
    .QUAT_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .operand(operand),
    .result(result)
  );

  operand_word_t pending_words[$];
  rotation_t     awaited_rotations[$];
  operand_word_t next_word;
  operand_word_t seen;
  rotation_t     want;
  logic          operand_took = 1'b0;
  int            words_in = 0;
  int            total_words = 0;
  int            mismatches = 0;
  int            cycles = 0;
  int            gap_left = 0;
  int            burst_left = 1;
  int            hold_left = 0;
  int            next_holdoff = 300;
  int            mode_left = 0;
  rx_pattern_t   rx_mode = RX_STREAM;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round half up, then clip to the output width
  function automatic logic signed [DW-1:0] round_clip(input longint cross_sum,
                                                      input longint v,
                                                      output logic clipped);
    longint r;
    r = (cross_sum + (v <<< SHIFT) + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
    clipped = 1'b0;
    if (r > ROT_MAX) begin
      clipped = 1'b1;
      r = ROT_MAX;
    end else if (r < ROT_MIN) begin
      clipped = 1'b1;
      r = ROT_MIN;
    end
    return r[DW-1:0];
  endfunction

  function automatic rotation_t rotate_vector(input operand_word_t op);
    longint w, x, y, z, vx, vy, vz;
    longint sx, sy, sz;
    logic cx, cy, cz;
    rotation_t r;
    w = op.quat_w;
    x = op.quat_x;
    y = op.quat_y;
    z = op.quat_z;
    vx = op.vec_x;
    vy = op.vec_y;
    vz = op.vec_z;
    sx = -(y * y + z * z) * vx + (x * y - w * z) * vy + (x * z + w * y) * vz;
    sy = (x * y + w * z) * vx - (x * x + z * z) * vy + (y * z - w * x) * vz;
    sz = (x * z - w * y) * vx + (y * z + w * x) * vy - (x * x + y * y) * vz;
    r.rot_x = round_clip(sx, vx, cx);
    r.rot_y = round_clip(sy, vy, cy);
    r.rot_z = round_clip(sz, vz, cz);
    r.saturated = cx | cy | cz;
    return r;
  endfunction

  task automatic add_word(input int w, input int x, input int y, input int z,
                          input int vx, input int vy, input int vz, input bit drain);
    operand_word_t op;
    op.quat_w = w[DW-1:0];
    op.quat_x = x[DW-1:0];
    op.quat_y = y[DW-1:0];
    op.quat_z = z[DW-1:0];
    op.vec_x = vx[DW-1:0];
    op.vec_y = vy[DW-1:0];
    op.vec_z = vz[DW-1:0];
    op.drain_first = drain;
    pending_words.push_back(op);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return 1;
      4: return -1;
      5: return 16384;
      6: return -16384;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [DW-1:0] exp_val,
                             input logic signed [DW-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  initial begin : stimulus
    int kind;
    int ra, rb, rc, rd;
    real norm, gain;
    rst = 1'b1;

    add_word(0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_word(16384, 0, 0, 0, 32767, -32768, 1, 1'b0);
    add_word(-16384, 0, 0, 0, -32768, 32767, -1, 1'b0);
    add_word(11585, 0, 0, 11585, 10000, 0, 0, 1'b0);
    add_word(0, 16384, 0, 0, 100, 200, 300, 1'b0);
    // half turn on a unit quaternion still clips the most negative input
    add_word(0, 0, 16384, 0, -32768, 32767, -32768, 1'b0);
    // exact halves: positive rounds up, negative rounds towards zero
    add_word(0, 0, 0, 8192, 1, 1, 0, 1'b0);
    add_word(0, 0, 0, 8192, -1, -1, 5, 1'b0);
    add_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
    add_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
    add_word(32767, -32768, 32767, -32768, -32768, 32767, -32768, 1'b0);
    add_word(-32768, 0, 0, 0, 12345, -12345, 32767, 1'b0);
    add_word(0, -32768, 0, 0, 10000, 10000, 10000, 1'b0);
    add_word(0, 0, -32768, 0, -1, 1, -1, 1'b0);
    add_word(0, 0, 0, -32768, 32767, 32767, 32767, 1'b0);
    add_word(16384, 1, -1, 0, 20000, -20000, 7, 1'b0);
    add_word(8192, 8192, 8192, 8192, 1, 2, 3, 1'b0);
    add_word(8192, -8192, 8192, -8192, -32768, -32768, 32767, 1'b0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5 || kind == 9) begin
        ra = int'($urandom_range(0, 32766)) - 16383;
        rb = int'($urandom_range(0, 32766)) - 16383;
        rc = int'($urandom_range(0, 32766)) - 16383;
        rd = int'($urandom_range(0, 32766)) - 16383;
        norm = $sqrt(real'(ra) * ra + real'(rb) * rb + real'(rc) * rc + real'(rd) * rd);
        if (norm < 1.0) norm = 1.0;
        gain = (kind == 9) ? 16384.0 + $urandom_range(0, 16383) : 16384.0;
        add_word($rtoi(ra * gain / norm), $rtoi(rb * gain / norm),
                 $rtoi(rc * gain / norm), $rtoi(rd * gain / norm),
                 $urandom, $urandom, $urandom, i == 0 || i == 500 || i == 1100);
      end else if (kind == 6) begin
        add_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 1'b0);
      end else if (kind == 7) begin
        add_word($urandom, $urandom, $urandom, $urandom,
                 int'($urandom_range(0, 64)) - 32, int'($urandom_range(0, 64)) - 32,
                 int'($urandom_range(0, 64)) - 32, 1'b0);
      end else begin
        add_word(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme(), pick_extreme(), pick_extreme(), 1'b0);
      end
    end
    total_words = pending_words.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (words_in != total_words || awaited_rotations.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("quaternion_vector_rotate_tb OK");
    else
      $display("quaternion_vector_rotate_tb NOT OK");
    $finish;
  end

  // operand driver: bursts and gaps, holds a word until it is taken
  always @(negedge clk) begin
    if (rst) begin
      operand.valid <= 1'b0;
      operand.quat_w <= '0;
      operand.quat_x <= '0;
      operand.quat_y <= '0;
      operand.quat_z <= '0;
      operand.vec_x <= '0;
      operand.vec_y <= '0;
      operand.vec_z <= '0;
    end else if (!operand.valid || operand_took) begin
      if (gap_left > 0) begin
        gap_left--;
        operand.valid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].drain_first && awaited_rotations.size() != 0)) begin
        operand.valid <= 1'b0;
      end else begin
        next_word = pending_words.pop_front();
        operand.quat_w <= next_word.quat_w;
        operand.quat_x <= next_word.quat_x;
        operand.quat_y <= next_word.quat_y;
        operand.quat_z <= next_word.quat_z;
        operand.vec_x <= next_word.vec_x;
        operand.vec_y <= next_word.vec_y;
        operand.vec_z <= next_word.vec_z;
        operand.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                   : $urandom_range(1, 20);
          gap_left = $urandom_range(0, 6);
        end
      end
    end
  end

  // result receiver: changing stall patterns plus two long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else if (next_holdoff != 0 && words_in >= next_holdoff) begin
      hold_left = 250;
      next_holdoff = (next_holdoff < 1000) ? 1000 : 0;
      result.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      case (rx_mode)
        RX_STREAM: result.ready <= 1'b1;
        RX_COIN: result.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: result.ready <= ($urandom_range(0, 3) == 0);
        default: result.ready <= (mode_left % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    operand_took <= !rst && operand.valid && operand.ready;
    if (!rst && operand.valid && operand.ready) begin
      seen.quat_w = operand.quat_w;
      seen.quat_x = operand.quat_x;
      seen.quat_y = operand.quat_y;
      seen.quat_z = operand.quat_z;
      seen.vec_x = operand.vec_x;
      seen.vec_y = operand.vec_y;
      seen.vec_z = operand.vec_z;
      seen.drain_first = 1'b0;
      awaited_rotations.push_back(rotate_vector(seen));
      words_in++;
    end
    if (!rst && result.valid && result.ready) begin
      if (awaited_rotations.size() == 0) begin
        $error("result word with none outstanding: rot_x %0d rot_y %0d rot_z %0d",
               result.rot_x, result.rot_y, result.rot_z);
        mismatches++;
      end else begin
        want = awaited_rotations.pop_front();
        check_field("rot_x", want.rot_x, result.rot_x);
        check_field("rot_y", want.rot_y, result.rot_y);
        check_field("rot_z", want.rot_z, result.rot_z);
        check_field("saturated", DW'(want.saturated), DW'(result.saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_vector_rotate_tb NOT OK");
      $finish;
    end
  end

endmodule
